// ===== src/slm_pkg.sv =====
package slm_pkg;

  localparam int unsigned DefMaxSteps = 32;
  localparam int unsigned StepsCap32 = 32;
  localparam logic [5:0] StepsReset = 6'd20;
  localparam logic [5:0] StepsMin = 6'd2;

  localparam logic [16:0] FullD = 17'd117760;
  localparam logic [16:0] OverMinD = 17'd113050;
  localparam logic [12:0] RecipMul = 13'd4560;

  localparam logic [7:0] GlyphSpace = 8'h20;

  typedef struct packed {
    logic signed [15:0] level_left;
    logic signed [15:0] level_right;
    logic               redraw;
  } slm_in_t;

  typedef struct packed {
    logic [3:0] cell_index;
    logic [7:0] glyph_code;
    logic       overload_light;
    logic       clip_light;
    logic       last_cell;
  } slm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEFL,
    ST_SCALE,
    ST_RECIP,
    ST_CHECK,
    ST_EMIT
  } slm_state_t;

  typedef struct packed {
    logic load;
    logic defl;
    logic scale;
    logic recip;
    logic commit;
    logic next_cell;
  } slm_cmd_t;

  typedef struct packed {
    logic changed;
    logic last;
  } slm_sts_t;

  function automatic logic [7:0] glyph_lookup(input logic [3:0] v);
    logic [7:0] g;
    case (v)
      4'd0:    g = GlyphSpace;
      4'd1:    g = 8'h08;
      4'd2:    g = 8'h01;
      4'd3:    g = 8'h01;
      4'd4:    g = 8'h02;
      4'd5:    g = 8'h03;
      4'd6:    g = 8'h03;
      4'd7:    g = 8'h04;
      4'd8:    g = 8'h05;
      4'd9:    g = 8'h06;
      4'd10:   g = GlyphSpace;
      4'd11:   g = GlyphSpace;
      4'd12:   g = 8'h05;
      4'd13:   g = 8'h06;
      4'd14:   g = 8'h07;
      4'd15:   g = 8'h07;
      default: g = GlyphSpace;
    endcase
    return g;
  endfunction

endpackage

// ===== src/slm_ctrl.sv =====
module slm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  input  slm_pkg::slm_sts_t sts,
  output slm_pkg::slm_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import slm_pkg::*;

  slm_state_t state_r;
  slm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DEFL;
        end
      end
      ST_DEFL:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.changed) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_stall && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DEFL:  cmd.defl = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_RECIP: cmd.recip = 1'b1;
      ST_CHECK: cmd.commit = sts.changed;
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.next_cell = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/slm_dp.sv =====
module slm_dp #(
  parameter int unsigned MAX_STEPS = slm_pkg::DefMaxSteps
) (
  input  logic              clk,
  input  logic              rst_n,
  input  slm_pkg::slm_in_t  in_data,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  input  slm_pkg::slm_cmd_t cmd,
  output slm_pkg::slm_sts_t sts,
  output slm_pkg::slm_out_t out_data
);
  import slm_pkg::*;

  localparam int unsigned Cap = (MAX_STEPS < StepsCap32) ? MAX_STEPS : StepsCap32;

  logic [5:0]         cfg_steps_r;
  logic signed [15:0] lvl_l_r;
  logic signed [15:0] lvl_r_r;
  logic               redraw_r;
  logic [5:0]         steps_r;
  logic [16:0]        dl_r;
  logic [16:0]        dr_r;
  logic               over_r;
  logic               clip_r;
  logic [11:0]        ql_r;
  logic [11:0]        qr_r;
  logic [5:0]         fl_r;
  logic [5:0]         fr_r;
  logic [5:0]         prev_l_r;
  logic [5:0]         prev_r_r;
  logic [3:0]         cell_r;

  logic [5:0]  steps_eff;
  logic [16:0] dl_nxt;
  logic [16:0] dr_nxt;
  logic [22:0] prod_l;
  logic [22:0] prod_r;
  logic [24:0] rec_l;
  logic [24:0] rec_r;
  logic [4:0]  cells;
  logic [5:0]  j_lo;
  logic [5:0]  j_hi;
  logic [3:0]  quad;

  function automatic logic [16:0] deflect(input logic signed [15:0] x);
    logic signed [17:0] xe;
    logic signed [17:0] d;
    xe = {{2{x[15]}}, x};
    if (xe < -18'sd17920) begin
      d = '0;
    end else if (xe >= 18'sd1536) begin
      d = $signed({1'b0, FullD});
    end else if (xe < -18'sd15360) begin
      d = xe + 18'sd17920;
    end else if (xe < -18'sd12800) begin
      d = 18'sd2 * (xe + 18'sd15360) + 18'sd2560;
    end else if (xe < -18'sd10240) begin
      d = 18'sd3 * (xe + 18'sd12800) + 18'sd7680;
    end else if (xe < -18'sd7680) begin
      d = 18'sd6 * (xe + 18'sd10240) + 18'sd15360;
    end else if (xe < -18'sd5120) begin
      d = 18'sd8 * (xe + 18'sd7680) + 18'sd30720;
    end else begin
      d = 18'sd10 * (xe + 18'sd5120) + 18'sd51200;
    end
    return d[16:0];
  endfunction

  always_comb begin
    steps_eff = cfg_steps_r;
    if (steps_eff > 6'(Cap)) begin
      steps_eff = 6'(Cap);
    end
    if (steps_eff < StepsMin) begin
      steps_eff = StepsMin;
    end
    steps_eff = {steps_eff[5:1], 1'b0};
  end

  assign dl_nxt = deflect(lvl_l_r);
  assign dr_nxt = deflect(lvl_r_r);
  assign prod_l = 23'(dl_r) * 23'(steps_r);
  assign prod_r = 23'(dr_r) * 23'(steps_r);
  assign rec_l  = 25'(ql_r) * 25'(RecipMul);
  assign rec_r  = 25'(qr_r) * 25'(RecipMul);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_steps_r <= StepsReset;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
    end else begin
      if (cfg_we) begin
        cfg_steps_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        prev_l_r <= fl_r;
        prev_r_r <= fr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl_l_r  <= in_data.level_left;
      lvl_r_r  <= in_data.level_right;
      redraw_r <= in_data.redraw;
      steps_r  <= steps_eff;
    end
    if (cmd.defl) begin
      dl_r   <= dl_nxt;
      dr_r   <= dr_nxt;
      over_r <= (dl_nxt >= OverMinD) || (dr_nxt >= OverMinD);
      clip_r <= (dl_nxt == FullD) || (dr_nxt == FullD);
    end
    if (cmd.scale) begin
      ql_r <= prod_l[21:10];
      qr_r <= prod_r[21:10];
    end
    if (cmd.recip) begin
      fl_r <= rec_l[24:19];
      fr_r <= rec_r[24:19];
    end
    if (cmd.commit) begin
      cell_r <= '0;
    end else if (cmd.next_cell) begin
      cell_r <= cell_r + 4'd1;
    end
  end

  assign cells = steps_r[5:1];
  assign j_lo  = {1'b0, cell_r, 1'b1};
  assign j_hi  = j_lo + 6'd1;
  assign quad  = {fr_r >= j_hi, fr_r >= j_lo, fl_r >= j_hi, fl_r >= j_lo};

  assign sts.changed = (fl_r != prev_l_r) || (fr_r != prev_r_r) || redraw_r;
  assign sts.last    = ({1'b0, cell_r} == (cells - 5'd1));

  assign out_data.cell_index     = cell_r;
  assign out_data.glyph_code     = glyph_lookup(quad);
  assign out_data.overload_light = over_r;
  assign out_data.clip_light     = clip_r;
  assign out_data.last_cell      = sts.last;

endmodule

// ===== src/stereo_log_meter_lcd_cells.sv =====
// Channel   Direction  Handshake          Payload
// in_*      input      in_valid/in_stall  slm_in_t: left level, right level, redraw
// out_*     output     out_valid/out_stall slm_out_t: cell index, glyph, lights, last
// cfg_*     input      cfg_we             cfg_wdata: number of fill steps
//
// An item passes through deflection, scaling, the reciprocal multiply and a
// change check, then one cell per cycle while the output is not stalled: no
// cells when nothing changes, steps/2 cells otherwise.
// The controller walks one item at a time, so in_stall stays high until the
// last cell has been taken. Reset is synchronous and active low; it sets the
// step count to 20 and clears the stored fills.
module stereo_log_meter_lcd_cells #(
  parameter int unsigned MAX_STEPS = slm_pkg::DefMaxSteps
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  slm_pkg::slm_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output slm_pkg::slm_out_t out_data,
  input  logic             cfg_we,
  input  logic [5:0]       cfg_wdata
);
  import slm_pkg::*;

  slm_cmd_t cmd;
  slm_sts_t sts;

  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  slm_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input item accepted while cells are being emitted");

  a_last_ends_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_cell |=> !out_valid)
    else $error("cell emitted after the last cell of an update");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_cell |=>
      out_valid && (out_data.cell_index == $past(out_data.cell_index) + 4'd1))
    else $error("cell index did not advance by one");

  a_lights_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_cell |=>
      out_data.clip_light == $past(out_data.clip_light) &&
      out_data.overload_light == $past(out_data.overload_light))
    else $error("lights changed within one update");

  a_clip_implies_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clip_light |-> out_data.overload_light)
    else $error("clip shown without overload");

endmodule
